// ===== src/sps_pkg.sv =====
// Package for the signal pending selector: field widths, opcodes, signal
// numbers, disposition codes and the per-signal disposition function.
// Depends on nothing; every other file of the block uses it.
package sps_pkg;

   localparam int MASK_WIDTH       = 64;
   localparam int OPCODE_WIDTH     = 3;
   localparam int SIGNUM_WIDTH     = 7;
   localparam int DISP_WIDTH       = 3;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int SIGNAL_COUNT_DEF = 64;

   typedef logic [OPCODE_WIDTH-1:0] opcode_type;
   typedef logic [SIGNUM_WIDTH-1:0] signum_type;
   typedef logic [DISP_WIDTH-1:0]   disp_type;

   localparam opcode_type OP_POST_THREAD  = 3'd0;
   localparam opcode_type OP_POST_PROCESS = 3'd1;
   localparam opcode_type OP_CONSUME      = 3'd2;
   localparam opcode_type OP_QUERY        = 3'd3;
   localparam opcode_type OP_CLEAR        = 3'd4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCKED = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAUGHT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IGNORED = 2'd2;

   localparam signum_type SIG_KILL  = 7'd9;
   localparam signum_type SIG_CHLD  = 7'd17;
   localparam signum_type SIG_CONT  = 7'd18;
   localparam signum_type SIG_STOP  = 7'd19;
   localparam signum_type SIG_TTOU  = 7'd22;
   localparam signum_type SIG_URG   = 7'd23;
   localparam signum_type SIG_WINCH = 7'd28;

   localparam disp_type ACT_NONE    = 3'd0;
   localparam disp_type ACT_TERM    = 3'd1;
   localparam disp_type ACT_STOP    = 3'd2;
   localparam disp_type ACT_CONT    = 3'd3;
   localparam disp_type ACT_IGNORE  = 3'd4;
   localparam disp_type ACT_HANDLER = 3'd5;

   localparam logic [MASK_WIDTH-1:0] CONT_BIT_MASK    = 64'h0000_0000_0002_0000;
   localparam logic [MASK_WIDTH-1:0] STOP_GROUP_MASK  = 64'h0000_0000_003C_0000;
   localparam logic [MASK_WIDTH-1:0] UNBLOCKABLE_MASK = 64'h0000_0000_0004_0100;

   // Result of one item, passed from the selector to the result register.
   typedef struct packed {
      signum_type next_signal;
      disp_type   disposition;
      logic       interrupt;
   } result_type;

   function automatic logic is_stop_signal(input signum_type n);
      return (n >= SIG_STOP) && (n <= SIG_TTOU);
   endfunction

   // Disposition of signal n given its ignored and caught bits.
   function automatic disp_type sig_disp(input signum_type n, input logic ign,
                                         input logic caught);
      disp_type d;
      if (n == SIG_KILL) begin
         d = ACT_TERM;
      end else if (n == SIG_STOP) begin
         d = ACT_STOP;
      end else if (ign) begin
         d = ACT_IGNORE;
      end else if (caught) begin
         d = ACT_HANDLER;
      end else if (n == SIG_CHLD || n == SIG_URG || n == SIG_WINCH) begin
         d = ACT_IGNORE;
      end else if (n == SIG_CONT) begin
         d = ACT_CONT;
      end else if (is_stop_signal(n)) begin
         d = ACT_STOP;
      end else begin
         d = ACT_TERM;
      end
      return d;
   endfunction

endpackage

// ===== src/sps_select.sv =====
// Delivery selector: from the pending and blocking masks it finds the lowest
// deliverable signal, its disposition and the interrupt flag.
// Depends on sps_pkg.
module sps_select #(
   parameter int SIGNAL_COUNT = sps_pkg::SIGNAL_COUNT_DEF
) (
   input  logic [SIGNAL_COUNT-1:0] pending,
   input  logic [SIGNAL_COUNT-1:0] blocked,
   input  logic [SIGNAL_COUNT-1:0] caught,
   input  logic [SIGNAL_COUNT-1:0] ignored,
   output sps_pkg::result_type     result
);

   localparam logic [SIGNAL_COUNT-1:0] UNBLOCKABLE =
      sps_pkg::UNBLOCKABLE_MASK[SIGNAL_COUNT-1:0];

   logic [SIGNAL_COUNT-1:0] deliverable;
   logic [SIGNAL_COUNT-1:0] lowest;
   logic [SIGNAL_COUNT-1:0] lane_int;
   sps_pkg::disp_type       lane_disp [SIGNAL_COUNT];

   assign deliverable = pending & (~blocked | UNBLOCKABLE);
   assign lowest      = deliverable & (~deliverable + {{(SIGNAL_COUNT-1){1'b0}}, 1'b1});

   for (genvar i = 0; i < SIGNAL_COUNT; i++) begin : g_lane
      assign lane_disp[i] = sps_pkg::sig_disp(sps_pkg::SIGNUM_WIDTH'(i + 1), ignored[i],
                                              caught[i]);
      assign lane_int[i]  = deliverable[i] &&
                            (lane_disp[i] == sps_pkg::ACT_TERM ||
                             lane_disp[i] == sps_pkg::ACT_STOP ||
                             lane_disp[i] == sps_pkg::ACT_HANDLER);
   end

   always_comb begin
      result.next_signal = '0;
      result.disposition = sps_pkg::ACT_NONE;
      for (int i = 0; i < SIGNAL_COUNT; i++) begin
         if (lowest[i]) begin
            result.next_signal = result.next_signal | sps_pkg::SIGNUM_WIDTH'(i + 1);
            result.disposition = result.disposition | lane_disp[i];
         end
      end
      result.interrupt = |lane_int;
   end

endmodule

// ===== src/signal_pending_selector.sv =====
// Top level of the signal pending selector: item register, pending mask
// update, result register and configuration registers.
// Depends on sps_pkg and sps_select.

// The block accepts one item per clock cycle unless the input stalls. An
// accepted item is captured in an input register; when it advances, the
// pending masks are updated and the lowest deliverable signal, its
// disposition and the interrupt flag are written to the result register and
// offered. Mask update and priority selection are combinational, so items
// can follow back to back. The input stalls only while the input register
// holds an item and a waiting result is not taken. Configuration writes
// take effect on the next item.
module signal_pending_selector #(
   parameter int SIGNAL_COUNT = sps_pkg::SIGNAL_COUNT_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  sps_pkg::opcode_type                    req_opcode,
   input  sps_pkg::signum_type                    req_signal_number,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output sps_pkg::signum_type                    rsp_next_signal,
   output sps_pkg::disp_type                      rsp_next_disposition,
   output logic                                   rsp_has_interrupt,
   input  logic                                   csr_wen,
   input  logic [sps_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [sps_pkg::MASK_WIDTH-1:0]         csr_wdata
);

   localparam int IDX_WIDTH = $clog2(SIGNAL_COUNT);
   localparam logic [SIGNAL_COUNT-1:0] STOP_GROUP =
      sps_pkg::STOP_GROUP_MASK[SIGNAL_COUNT-1:0];
   localparam logic [SIGNAL_COUNT-1:0] CONT_BIT =
      sps_pkg::CONT_BIT_MASK[SIGNAL_COUNT-1:0];
   localparam sps_pkg::signum_type SIG_LIMIT = sps_pkg::SIGNUM_WIDTH'(SIGNAL_COUNT);

   logic                    stage_valid_ff, stage_valid_in;
   sps_pkg::opcode_type     stage_op_ff;
   sps_pkg::signum_type     stage_sn_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   sps_pkg::result_type     result_ff, result_in;
   logic [SIGNAL_COUNT-1:0] thread_ff, thread_in;
   logic [SIGNAL_COUNT-1:0] process_ff, process_in;
   logic [SIGNAL_COUNT-1:0] blocked_ff, caught_ff, ignored_ff;

   logic                    advance;
   logic                    sn_valid;
   sps_pkg::signum_type     sn_minus_one;
   logic [SIGNAL_COUNT-1:0] sig_onehot;
   logic [SIGNAL_COUNT-1:0] keep_mask;

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;

   assign stage_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : stage_valid_ff);
   assign rsp_valid_in   = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign sn_valid     = (stage_sn_ff != '0) && (stage_sn_ff <= SIG_LIMIT);
   assign sn_minus_one = stage_sn_ff - sps_pkg::SIGNUM_WIDTH'(1);
   assign sig_onehot   = {{(SIGNAL_COUNT-1){1'b0}}, 1'b1} << sn_minus_one[IDX_WIDTH-1:0];

   // A posted SIGCONT discards pending stop signals, and a stop signal
   // discards a pending SIGCONT.
   always_comb begin
      if (stage_sn_ff == sps_pkg::SIG_CONT) begin
         keep_mask = ~STOP_GROUP;
      end else if (sps_pkg::is_stop_signal(stage_sn_ff)) begin
         keep_mask = ~CONT_BIT;
      end else begin
         keep_mask = '1;
      end
   end

   always_comb begin
      thread_in  = thread_ff;
      process_in = process_ff;
      case (stage_op_ff)
         sps_pkg::OP_POST_THREAD: begin
            if (sn_valid) begin
               thread_in = (thread_ff & keep_mask) | sig_onehot;
            end
         end
         sps_pkg::OP_POST_PROCESS: begin
            if (sn_valid) begin
               process_in = (process_ff & keep_mask) | sig_onehot;
            end
         end
         sps_pkg::OP_CONSUME: begin
            if (sn_valid) begin
               thread_in  = thread_ff & ~sig_onehot;
               process_in = process_ff & ~sig_onehot;
            end
         end
         sps_pkg::OP_CLEAR: begin
            thread_in  = '0;
            process_in = '0;
         end
         default: begin
            thread_in  = thread_ff;
            process_in = process_ff;
         end
      endcase
   end

   sps_select #(
      .SIGNAL_COUNT(SIGNAL_COUNT)
   ) u_select (
      .pending (thread_in | process_in),
      .blocked (blocked_ff),
      .caught  (caught_ff),
      .ignored (ignored_ff),
      .result  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         thread_ff      <= '0;
         process_ff     <= '0;
         blocked_ff     <= '0;
         caught_ff      <= '0;
         ignored_ff     <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            thread_ff  <= thread_in;
            process_ff <= process_in;
         end
         if (csr_wen) begin
            case (csr_index)
               sps_pkg::CSR_BLOCKED: blocked_ff <= csr_wdata[SIGNAL_COUNT-1:0];
               sps_pkg::CSR_CAUGHT:  caught_ff  <= csr_wdata[SIGNAL_COUNT-1:0];
               sps_pkg::CSR_IGNORED: ignored_ff <= csr_wdata[SIGNAL_COUNT-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_op_ff <= req_opcode;
         stage_sn_ff <= req_signal_number;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_next_signal      = result_ff.next_signal;
   assign rsp_next_disposition = result_ff.disposition;
   assign rsp_has_interrupt    = result_ff.interrupt;

`ifndef ASSERT_OFF
   a_reset_clears_pending: assert property (@(posedge clock)
      reset |=> (thread_ff == '0 && process_ff == '0))
      else $error("pending masks not cleared by reset");

   a_stall_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (stage_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked item");

   a_none_has_no_disp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_next_signal == '0) |-> (rsp_next_disposition == sps_pkg::ACT_NONE))
      else $error("disposition given without a deliverable signal");

   a_signal_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_next_signal != '0) |->
      (rsp_next_signal <= SIG_LIMIT && rsp_next_disposition != sps_pkg::ACT_NONE))
      else $error("selected signal out of range or without disposition");

   a_cont_cancels_stop: assert property (@(posedge clock) disable iff (reset)
      (advance && stage_op_ff == sps_pkg::OP_POST_THREAD &&
       stage_sn_ff == sps_pkg::SIG_CONT && sn_valid) |=> ((thread_ff & STOP_GROUP) == '0))
      else $error("stop signals still pending after SIGCONT");
`endif

endmodule
